// ----- rtl/core/avccab_pkg.sv -----
// Shared types and constants for the decoder configuration record to Annex B converter.
package avccab_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command kinds handed from the parser to the emitter.
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_DATA  = 2'd2;

   localparam logic [BYTE_W-1:0] START_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] START_ONE  = 8'h01;

   typedef struct packed {
      logic [1:0]        kind;
      logic              has_status;
      logic              status;
      logic [BYTE_W-1:0] data;
   } cmd_type;

endpackage

// ----- rtl/core/avccab_front.sv -----
// Parser that walks the configuration record and turns each byte that yields output into an emit command.
module avccab_front import avccab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_last,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_COUNT   = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   localparam logic [2:0]        HEADER_BYTES   = 3'd5;
   localparam logic [BYTE_W-1:0] SEQ_COUNT_MASK = 8'h1F;

   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        header_count_ff, header_count_in;
   logic              picture_sets_ff, picture_sets_in;
   logic [7:0]        units_left_ff, units_left_in;
   logic [7:0]        length_high_ff, length_high_in;
   logic [15:0]       payload_left_ff, payload_left_in;
   logic              end_unit, end_section;
   logic              accept;
   cmd_type           cmd;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      picture_sets_in = picture_sets_ff;
      units_left_in   = units_left_ff;
      length_high_in  = length_high_ff;
      payload_left_in = payload_left_ff;
      end_unit        = 1'b0;
      end_section     = 1'b0;
      cmd.kind        = CMD_NONE;
      cmd.has_status  = 1'b0;
      cmd.status      = 1'b0;
      cmd.data        = in_byte;

      case (phase_ff)
         PH_HEADER: begin
            header_count_in = header_count_ff + 3'd1;
            if (header_count_in >= HEADER_BYTES) begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            units_left_in = picture_sets_ff ? in_byte : (in_byte & SEQ_COUNT_MASK);
            if (units_left_in == 8'd0) begin
               end_section = 1'b1;
            end else begin
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            length_high_in = in_byte;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            payload_left_in = {length_high_ff, in_byte};
            cmd.kind        = CMD_START;
            if (payload_left_in == 16'd0) begin
               end_unit = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            cmd.kind        = CMD_DATA;
            payload_left_in = payload_left_ff - 16'd1;
            if (payload_left_in == 16'd0) begin
               end_unit = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (end_unit) begin
         units_left_in = units_left_ff - 8'd1;
         if (units_left_in == 8'd0) begin
            end_section = 1'b1;
         end else begin
            phase_in = PH_LEN_HI;
         end
      end

      if (end_section) begin
         if (picture_sets_ff) begin
            phase_in = PH_DONE;
         end else begin
            picture_sets_in = 1'b1;
            phase_in        = PH_COUNT;
         end
      end

      // The final byte closes the record and returns the parser to its start.
      if (in_last) begin
         cmd.has_status  = 1'b1;
         cmd.status      = (phase_in != PH_DONE);
         phase_in        = PH_HEADER;
         header_count_in = 3'd0;
         picture_sets_in = 1'b0;
         units_left_in   = 8'd0;
         length_high_in  = 8'd0;
         payload_left_in = 16'd0;
      end
   end

   assign q_push = accept && ((cmd.kind != CMD_NONE) || cmd.has_status);
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 3'd0;
         picture_sets_ff <= 1'b0;
         units_left_ff   <= 8'd0;
         length_high_ff  <= 8'd0;
         payload_left_ff <= 16'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         picture_sets_ff <= picture_sets_in;
         units_left_ff   <= units_left_in;
         length_high_ff  <= length_high_in;
         payload_left_ff <= payload_left_in;
      end
   end

endmodule

// ----- rtl/core/avccab_queue.sv -----
// Short command queue between the parser and the emitter.
module avccab_queue import avccab_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

// ----- rtl/core/avccab_back.sv -----
// Emitter that expands queued commands into output items through an output register.
module avccab_back import avccab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cmd_type           q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_is_status,
   output logic              out_status,
   output logic              out_run_last
);

   logic [2:0]        step_ff, step_in;
   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              is_status_ff, is_status_in;
   logic              status_ff, status_in;
   logic              run_last_ff, run_last_in;
   logic [2:0]        total;
   logic              load;

   assign load = !q_empty && (!valid_ff || out_ready);

   // Each command yields its start code or data byte, then optionally the status item.
   always_comb begin
      total = {2'b00, q_head.has_status};
      case (q_head.kind)
         CMD_START: total = total + 3'd4;
         CMD_DATA:  total = total + 3'd1;
         default:   total = total;
      endcase

      byte_in      = START_ZERO;
      is_status_in = 1'b0;
      status_in    = 1'b0;
      case (q_head.kind)
         CMD_START: begin
            if (step_ff == 3'd3) begin
               byte_in = START_ONE;
            end else if (step_ff == 3'd4) begin
               is_status_in = 1'b1;
               status_in    = q_head.status;
            end
         end
         CMD_DATA: begin
            if (step_ff == 3'd0) begin
               byte_in = q_head.data;
            end else begin
               is_status_in = 1'b1;
               status_in    = q_head.status;
            end
         end
         default: begin
            is_status_in = 1'b1;
            status_in    = q_head.status;
         end
      endcase

      run_last_in = (step_ff == total - 3'd1);
      step_in     = step_ff;
      if (load) begin
         step_in = run_last_in ? 3'd0 : step_ff + 3'd1;
      end
   end

   assign q_pop = load && run_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         step_ff <= step_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff      <= byte_in;
         is_status_ff <= is_status_in;
         status_ff    <= status_in;
         run_last_ff  <= run_last_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_byte      = byte_ff;
   assign out_is_status = is_status_ff;
   assign out_status    = status_ff;
   assign out_run_last  = run_last_ff;

endmodule

// ----- rtl/core/avcc_config_to_annexb_param_sets.sv -----
// Top level of the decoder configuration record to Annex B parameter set converter.
//
// The req channel takes one record byte per item in req_tdata, with req_tlast on the
// final byte of the record. The parser skips the header, reads the set counts and
// unit lengths, and queues one command per byte that yields output. The emitter
// turns each command into rsp items: four start code bytes after a unit length,
// one payload byte per payload byte in, and a status item (rsp_tuser[0] high) on
// the byte marked last. rsp_tlast marks the final item caused by one input byte.
// A byte passes the command queue and the output register before its first result.
// Payload bytes flow at one item per cycle while rsp_tready is high; a start code
// is four items, and the input stalls only once the four-entry queue fills.
// Synchronous reset clears the parser, empties the queue and drops any pending
// result. When rsp_tready is low the output register holds its item, the queue
// absorbs up to four further commands and then req_tready falls.
// After the byte marked last the parser is back at its start for the next record.
module avcc_config_to_annexb_param_sets import avccab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0]        rsp_tuser,   // [0] is_status, [1] status
   output logic              rsp_tlast
);

   logic    q_full, q_empty, q_push, q_pop;
   cmd_type push_cmd, head_cmd;
   logic    is_status, status;

   avccab_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   avccab_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   avccab_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (head_cmd),
      .q_pop         (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_is_status (is_status),
      .out_status    (status),
      .out_run_last  (rsp_tlast)
   );

   assign rsp_tuser = {status, is_status};

endmodule

// ----- tb/sv/annexb_checker.sv -----
// Checker that predicts and compares the Annex B output of the configuration record converter.
`timescale 1ns / 100ps

module annexb_checker import avccab_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   input  logic [1:0]        rsp_tuser,   // [0] is_status, [1] status
   input  logic              rsp_tlast,
   output int                failures,
   output int                pending,
   output int                results_seen,
   output int                records_seen
);

   localparam logic [2:0]        HEADER_LEN    = 3'd5;
   localparam logic [BYTE_W-1:0] SEQ_MASK      = 8'h1F;
   localparam logic              REC_COMPLETE  = 1'b0;
   localparam logic              REC_TRUNCATED = 1'b1;

   typedef enum logic [2:0] {
      ST_SKIP_HEADER = 3'd0,
      ST_COUNT       = 3'd1,
      ST_LEN_HIGH    = 3'd2,
      ST_LEN_LOW     = 3'd3,
      ST_PAYLOAD     = 3'd4,
      ST_FINISHED    = 3'd5
   } parse_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_status;
      logic              status;
      logic              run_last;
   } annexb_item_type;

   parse_state_type   pstate;
   logic [2:0]        header_count;
   logic              picture_sets;
   logic [7:0]        units_left;
   logic [7:0]        length_high;
   logic [15:0]       payload_left;
   annexb_item_type   annexb_due[$];

   assign pending = annexb_due.size();

   task automatic restart_parser();
      pstate       = ST_SKIP_HEADER;
      header_count = '0;
      picture_sets = 1'b0;
      units_left   = '0;
      length_high  = '0;
      payload_left = '0;
   endtask

   task automatic close_section();
      if (picture_sets) begin
         pstate = ST_FINISHED;
      end else begin
         picture_sets = 1'b1;
         pstate       = ST_COUNT;
      end
   endtask

   task automatic close_unit();
      units_left = units_left - 8'd1;
      if (units_left == 8'd0) begin
         close_section();
      end else begin
         pstate = ST_LEN_HIGH;
      end
   endtask

   task automatic emit(input logic [BYTE_W-1:0] b, input logic st, input logic stat);
      annexb_due.push_back('{out_byte: b, is_status: st, status: stat, run_last: 1'b0});
   endtask

   // Works out the output items that one accepted record byte causes.
   task automatic parse_record_byte(input logic [BYTE_W-1:0] b, input logic last);
      int added;
      added = annexb_due.size();
      case (pstate)
         ST_SKIP_HEADER: begin
            header_count = header_count + 3'd1;
            if (header_count >= HEADER_LEN) pstate = ST_COUNT;
         end
         ST_COUNT: begin
            units_left = picture_sets ? b : (b & SEQ_MASK);
            if (units_left == 8'd0) begin
               close_section();
            end else begin
               pstate = ST_LEN_HIGH;
            end
         end
         ST_LEN_HIGH: begin
            length_high = b;
            pstate      = ST_LEN_LOW;
         end
         ST_LEN_LOW: begin
            payload_left = {length_high, b};
            emit(START_ZERO, 1'b0, 1'b0);
            emit(START_ZERO, 1'b0, 1'b0);
            emit(START_ZERO, 1'b0, 1'b0);
            emit(START_ONE, 1'b0, 1'b0);
            if (payload_left == 16'd0) begin
               close_unit();
            end else begin
               pstate = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            emit(b, 1'b0, 1'b0);
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) close_unit();
         end
         default: ;
      endcase
      if (last) begin
         emit('0, 1'b1, (pstate == ST_FINISHED) ? REC_COMPLETE : REC_TRUNCATED);
         restart_parser();
      end
      if (annexb_due.size() > added) annexb_due[annexb_due.size() - 1].run_last = 1'b1;
   endtask

   always @(posedge clock) begin
      annexb_item_type want;
      if (reset) begin
         restart_parser();
         annexb_due.delete();
         failures     = 0;
         results_seen = 0;
         records_seen = 0;
      end else begin
         if (req_tvalid && req_tready) parse_record_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (annexb_due.size() == 0) begin
               $error("unexpected output item: byte %0h, tuser %0b, tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               failures++;
            end else begin
               want = annexb_due.pop_front();
               if (want.is_status) records_seen++;
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser[0] !== want.is_status) begin
                  $error("is_status: expected %0b, got %0b", want.is_status, rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tuser[1] !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_tuser[1]);
                  failures++;
               end
               if (rsp_tlast !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
                  failures++;
               end
            end
         end
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the testbench: clock, reset, record stimulus and the final verdict.
`timescale 1ns / 100ps

module tb import avccab_pkg::*; ();

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 105;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic [BYTE_W-1:0] req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tready = 1'b0;
   logic              req_tready;
   logic              rsp_tvalid;
   logic [BYTE_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;

   int failures, pending, results_seen, records_seen;
   int send_idle  = 0;
   int recv_idle  = 0;
   int items_sent = 0;
   int cycles     = 0;
   logic [BYTE_W-1:0] record_bytes[$];

   avcc_config_to_annexb_param_sets dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   annexb_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .failures     (failures),
      .pending      (pending),
      .results_seen (results_seen),
      .records_seen (records_seen)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Holds valid low for random idle cycles, then waits for the item to be taken.
   task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
   endtask

   task automatic send_bytes(input int count, input bit random_last);
      for (int i = 0; i < count; i++) begin
         send_item(record_bytes[i],
                   (i == count - 1) || (random_last && $urandom_range(7) == 0));
      end
   endtask

   // Broken units take random high length bytes; their payload is capped since the
   // record is cut short before it could end anyway.
   task automatic add_units(input int units, input bit broken);
      logic [7:0] hi, lo;
      int len;
      for (int u = 0; u < units; u++) begin
         if (broken && record_bytes.size() > 40) return;
         hi = broken ? 8'($urandom_range(255)) : 8'd0;
         lo = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
         if (!broken && lo > 8'd20) lo = 8'd20;
         record_bytes.push_back(hi);
         record_bytes.push_back(lo);
         len = int'({hi, lo});
         for (int j = 0; j < len && j < 24; j++) record_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic build_record(input bit broken);
      logic [7:0] cnt;
      record_bytes.delete();
      repeat (5) record_bytes.push_back(8'($urandom_range(255)));
      cnt = broken ? 8'($urandom_range(255)) : {3'($urandom_range(7)), 5'($urandom_range(3))};
      record_bytes.push_back(cnt);
      add_units(int'(cnt[4:0]), broken);
      cnt = broken ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      record_bytes.push_back(cnt);
      add_units(int'(cnt), broken);
   endtask

   task automatic send_random_record();
      int pick;
      pick = int'($urandom_range(9));
      if (pick < 7) begin
         build_record(1'b0);
         repeat ($urandom_range(2)) record_bytes.push_back(8'($urandom_range(255)));
         send_bytes(record_bytes.size(), 1'b0);
      end else if (pick < 9) begin
         build_record(1'b1);
         send_bytes(int'($urandom_range(1, record_bytes.size())), 1'b0);
      end else begin
         record_bytes.delete();
         repeat ($urandom_range(1, 8)) record_bytes.push_back(8'($urandom_range(255)));
         send_bytes(record_bytes.size(), 1'b1);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Masked sequence count, a zero-length unit, an empty picture section, trailing bytes.
      record_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'hE1, 8'h00, 8'h00, 8'h00,
                       8'h55, 8'hAA};
      send_bytes(record_bytes.size(), 1'b0);
      // A record that ends in its header.
      record_bytes = '{8'hFF};
      send_bytes(record_bytes.size(), 1'b0);
      // No sequence sets, then a picture set cut off inside its payload.
      record_bytes = '{8'h7F, 8'h80, 8'h01, 8'hFE, 8'h40, 8'h00, 8'h01, 8'h00, 8'h02,
                       8'hFF};
      send_bytes(record_bytes.size(), 1'b0);

      send_idle = 38;
      recv_idle = 73;
      while (items_sent < PHASE_ITEMS) send_random_record();
      send_idle = 73;
      recv_idle = 38;
      while (items_sent < 2 * PHASE_ITEMS) send_random_record();
      send_idle = 0;
      recv_idle = 0;
      while (items_sent < 3 * PHASE_ITEMS) send_random_record();
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb summary: %0d record bytes sent, %0d output items checked", items_sent,
               results_seen);
      $display("tb summary: %0d records ended with a status item over three stall mixes",
               records_seen);
      if (failures == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
